FILE: sv/crfgd_pkg.sv
// Shared types, constants and font function for the rectangle fill and glyph draw engine.
package crfgd_pkg;

  localparam int unsigned DIM_W = 10;
  localparam int unsigned IDX_W = 21;
  localparam int unsigned CNT_W = 19;

  localparam logic [31:0] CLEAR_COLOR = 32'hFF00_0000;
  localparam logic [9:0]  MIN_DIM     = 10'd8;
  localparam logic [9:0]  RESET_DIM   = 10'd8;
  localparam logic [3:0]  LAST_ROW    = 4'd15;
  localparam logic [2:0]  LAST_COL    = 3'd7;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_GLYPH = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_FILL  = 2'd1,
    K_GLYPH = 2'd2,
    K_READ  = 2'd3
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [31:0] color;
    logic [7:0]  char_code;
  } in_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic [18:0] pixels_written;
  } out_t;

  typedef struct packed {
    kind_e            kind;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] y0;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic [IDX_W-1:0] base;
    logic [31:0]      color;
    logic [7:0]       char_code;
  } desc_t;

  // Row r of glyph code: printable codes carry the code rotated left by (r - 2) mod 8 in rows 2 to 13, else zero.
  function automatic logic [7:0] font_row(input logic [7:0] code, input logic [3:0] r);
    logic [2:0]  s;
    logic [15:0] dbl;
    logic [7:0]  v;
    s   = 3'(r - 4'd2);
    dbl = {code, code} << s;
    v   = 8'h00;
    if ((code inside {[8'h21:8'h7E]}) && (r inside {[4'd2:4'd13]})) begin
      v = dbl[15:8];
    end
    return v;
  endfunction

endpackage

FILE: sv/crfgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crfgd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/crfgd_front.sv
// Front end: accept command beats, clip them and build draw descriptors.
module crfgd_front import crfgd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output logic             push_o,
  input  logic             full_i,
  output desc_t            desc_o
);

  logic             in_valid_q, in_valid_d;
  in_t              in_q;
  logic             x_in, y_in;
  logic [DIM_W-1:0] x10, y10, room_x, room_y;
  logic [19:0]      prod;
  desc_t            desc;

  assign push_o     = in_valid_q && !full_i;
  assign in_ready_o = !in_valid_q || push_o;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign x_in   = in_q.pos_x < {6'd0, width_i};
  assign y_in   = in_q.pos_y < {6'd0, height_i};
  assign x10    = in_q.pos_x[DIM_W-1:0];
  assign y10    = in_q.pos_y[DIM_W-1:0];
  assign room_x = width_i - x10;
  assign room_y = height_i - y10;

  always_comb begin
    desc           = '0;
    desc.color     = in_q.color;
    desc.char_code = in_q.char_code;
    desc.x0        = x10;
    desc.y0        = y10;
    case (in_q.op)
      OP_FILL: begin
        if ((in_q.rect_width != 16'd0) && (in_q.rect_height != 16'd0) && x_in && y_in) begin
          desc.kind = K_FILL;
        end
        desc.cols = (in_q.rect_width < {6'd0, room_x}) ? in_q.rect_width[DIM_W-1:0] : room_x;
        desc.rows = (in_q.rect_height < {6'd0, room_y}) ? in_q.rect_height[DIM_W-1:0] : room_y;
      end
      OP_CLEAR: begin
        desc.kind  = K_FILL;
        desc.x0    = '0;
        desc.y0    = '0;
        desc.cols  = width_i;
        desc.rows  = height_i;
        desc.color = CLEAR_COLOR;
      end
      OP_GLYPH: begin
        if (x_in && y_in) begin
          desc.kind = K_GLYPH;
        end
      end
      OP_READ: begin
        if (x_in && y_in) begin
          desc.kind = K_READ;
        end
      end
      default: desc.kind = K_NONE;
    endcase
    prod      = desc.y0 * width_i;
    desc.base = IDX_W'(prod) + IDX_W'(desc.x0);
  end

  assign desc_o = desc;

endmodule

FILE: sv/crfgd_queue.sv
// Two-entry descriptor queue between front and back.
module crfgd_queue import crfgd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t desc_o
);

  desc_t      entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign desc_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule

FILE: sv/crfgd_back.sv
// Back end: walk fills, glyphs and reads over the surface and emit result beats.
module crfgd_back import crfgd_pkg::*; #(
  parameter int unsigned PIXEL_WORDS = 262144,
  localparam int unsigned AW = (PIXEL_WORDS > 1) ? $clog2(PIXEL_WORDS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  input  desc_t            desc_i,
  output logic             pop_o,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic [31:0]      wdata_o,
  output logic [AW-1:0]    raddr_o,
  input  logic [31:0]      rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILL  = 6'b000010,
    ST_GLYPH = 6'b000100,
    ST_READ  = 6'b001000,
    ST_RDATA = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  desc_t            d_q;
  logic [DIM_W-1:0] row_q, row_d, col_q, col_d;
  logic [IDX_W-1:0] base_q, base_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      rd_q, rd_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q;
  logic             load_out;

  logic [IDX_W-1:0] idx;
  logic [31:0]      idx32, base32;
  logic             idx_ok, base_ok;
  logic [7:0]       bits;
  logic [DIM_W:0]   gx, gy;
  logic             glyph_on;

  assign idx     = base_q + IDX_W'(col_q);
  assign idx32   = 32'(idx);
  assign base32  = 32'(d_q.base);
  assign idx_ok  = idx32 < 32'(PIXEL_WORDS);
  assign base_ok = base32 < 32'(PIXEL_WORDS);
  assign bits    = font_row(d_q.char_code, row_q[3:0]);
  assign gx      = {1'b0, d_q.x0} + (DIM_W+1)'(col_q);
  assign gy      = {1'b0, d_q.y0} + (DIM_W+1)'(row_q);
  assign glyph_on = bits[LAST_COL - col_q[2:0]] && (gx < {1'b0, width_i})
                    && (gy < {1'b0, height_i});

  assign waddr_o = idx32[AW-1:0];
  assign raddr_o = base32[AW-1:0];
  assign wdata_o = d_q.color;
  assign pop_o   = (state_q == ST_IDLE) && desc_valid_i;

  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    rd_d    = rd_q;
    we_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (desc_valid_i) begin
          row_d  = '0;
          col_d  = '0;
          base_d = desc_i.base;
          cnt_d  = '0;
          rd_d   = '0;
          case (desc_i.kind)
            K_FILL:  state_d = ST_FILL;
            K_GLYPH: state_d = ST_GLYPH;
            K_READ:  state_d = ST_READ;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        we_o = idx_ok;
        if (idx_ok) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        col_d = col_q + DIM_W'(1);
        if (col_q == d_q.cols - DIM_W'(1)) begin
          col_d  = '0;
          base_d = base_q + IDX_W'(width_i);
          row_d  = row_q + DIM_W'(1);
          if (row_q == d_q.rows - DIM_W'(1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_GLYPH: begin
        we_o = glyph_on && idx_ok;
        if (glyph_on && idx_ok) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        col_d = col_q + DIM_W'(1);
        if (col_q[2:0] == LAST_COL) begin
          col_d  = '0;
          base_d = base_q + IDX_W'(width_i);
          row_d  = row_q + DIM_W'(1);
          if (row_q[3:0] == LAST_ROW) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        rd_d    = base_ok ? rdata_i : 32'd0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    rd_q   <= rd_d;
    if (pop_o) begin
      d_q <= desc_i;
    end
    if (load_out) begin
      out_q.read_color     <= rd_q;
      out_q.pixels_written <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/clipped_rect_fill_and_glyph_draw.sv
// Top level: surface size registers, front, queue, back and surface memory.
// The back end walks a fill or clear over its clipped pixels and a glyph over 16 rows by 8
// columns, one position per cycle; a read waits for the registered surface data.
// The back end takes a new command only once the last result beat has been loaded;
// the front register and the two-entry queue take up to three beats ahead of the back end.
// Reset clears control state and sets both size registers to 8; the surface is not cleared.
module clipped_rect_fill_and_glyph_draw import crfgd_pkg::*; #(
  parameter int unsigned MAX_DIM     = 512,
  parameter int unsigned PIXEL_WORDS = 262144,
  localparam int unsigned AW = (PIXEL_WORDS > 1) ? $clog2(PIXEL_WORDS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic             cfg_we;

  logic             push, full, pop, desc_valid;
  desc_t            front_desc, queue_desc;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      wdata, rdata;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) begin
      r = MIN_DIM;
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {22'd0, height_q} : {22'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_DIM;
      height_q <= RESET_DIM;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        height_q <= pwdata[DIM_W-1:0];
      end else begin
        width_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign width_eff  = eff_dim(width_q);
  assign height_eff = eff_dim(height_q);

  crfgd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .push_o     (push),
    .full_i     (full),
    .desc_o     (front_desc)
  );

  crfgd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (desc_valid),
    .desc_o  (queue_desc)
  );

  crfgd_back #(
    .PIXEL_WORDS (PIXEL_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (queue_desc),
    .pop_o        (pop),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  crfgd_ram #(
    .WIDTH (32),
    .DEPTH (PIXEL_WORDS)
  ) u_surface (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

FILE: bench/clipped_rect_fill_and_glyph_draw_tb.sv
// Self-checking bench: directed and random draw commands against a surface model.
module clipped_rect_fill_and_glyph_draw_tb;
  import crfgd_pkg::*;

  localparam int unsigned SURF_MAX    = 512;
  localparam int unsigned SURF_WORDS  = 262144;
  localparam int unsigned CHEAP_AREA  = 4096;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam logic [2:0]  ADDR_WIDTH  = 3'd0;
  localparam logic [2:0]  ADDR_HEIGHT = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  logic [31:0] surf_word [SURF_WORDS];
  bit          surf_set  [SURF_WORDS];
  logic [9:0]  width_reg;
  logic [9:0]  height_reg;
  out_t        draw_results_q [$];
  int unsigned err_count;
  int unsigned cmd_count;
  int unsigned result_count;
  int unsigned op_count [4];
  int unsigned last_x;
  int unsigned last_y;
  bit          idle_on;
  bit          hold_go;

  clipped_rect_fill_and_glyph_draw u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [9:0] raw);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > 10'(SURF_MAX)) return SURF_MAX;
    return raw;
  endfunction

  function automatic logic [7:0] glyph_row(input logic [7:0] code, input int unsigned r);
    logic [7:0] v;
    v = code;
    if (code < 8'h21 || code > 8'h7E || r < 2 || r > 13) return 8'h00;
    repeat ((r - 2) % 8) v = {v[6:0], v[7]};
    return v;
  endfunction

  function automatic bit plot(input int unsigned x, input int unsigned y,
                              input int unsigned w, input logic [31:0] argb);
    longint unsigned idx;
    idx = longint'(y) * w + x;
    if (idx >= SURF_WORDS) return 1'b0;
    surf_word[idx] = argb;
    surf_set[idx]  = 1'b1;
    return 1'b1;
  endfunction

  function automatic int unsigned fill_rect(input int unsigned x, input int unsigned y,
                                            input int unsigned rw, input int unsigned rh,
                                            input logic [31:0] argb,
                                            input int unsigned w, input int unsigned h);
    int unsigned n;
    n = 0;
    if (rw == 0 || rh == 0 || x >= w || y >= h) return 0;
    if (rw > w - x) rw = w - x;
    if (rh > h - y) rh = h - y;
    for (int unsigned r = 0; r < rh; r++) begin
      for (int unsigned k = 0; k < rw; k++) begin
        if (plot(x + k, y + r, w, argb)) n++;
      end
    end
    return n;
  endfunction

  function automatic out_t predict_draw(input in_t c);
    int unsigned     w;
    int unsigned     h;
    int unsigned     n;
    logic [31:0]     rd;
    logic [7:0]      row_bits;
    longint unsigned idx;
    out_t            res;
    w  = clamp_dim(width_reg);
    h  = clamp_dim(height_reg);
    n  = 0;
    rd = '0;
    case (c.op)
      OP_FILL: begin
        n = fill_rect(c.pos_x, c.pos_y, c.rect_width, c.rect_height, c.color, w, h);
      end
      OP_CLEAR: begin
        n = fill_rect(0, 0, w, h, CLEAR_COLOR, w, h);
      end
      OP_GLYPH: begin
        for (int unsigned r = 0; r < 16; r++) begin
          row_bits = glyph_row(c.char_code, r);
          if (row_bits != 8'h00 && c.pos_y + r < h) begin
            for (int unsigned k = 0; k < 8; k++) begin
              if (row_bits[7 - k] && c.pos_x + k < w) begin
                if (plot(c.pos_x + k, c.pos_y + r, w, c.color)) n++;
              end
            end
          end
        end
      end
      default: begin
        if (c.pos_x < w && c.pos_y < h) begin
          idx = longint'(c.pos_y) * w + c.pos_x;
          if (idx < SURF_WORDS) rd = surf_word[idx];
        end
      end
    endcase
    res.read_color     = rd;
    res.pixels_written = CNT_W'(n);
    return res;
  endfunction

  function automatic in_t draw_cmd(input op_e op, input int unsigned x, input int unsigned y,
                                   input int unsigned rw, input int unsigned rh,
                                   input logic [31:0] color, input logic [7:0] code);
    in_t c;
    c.op          = op;
    c.pos_x       = 16'(x);
    c.pos_y       = 16'(y);
    c.rect_width  = 16'(rw);
    c.rect_height = 16'(rh);
    c.color       = color;
    c.char_code   = code;
    return c;
  endfunction

  // Keep random commands cheap and never read a word that was never written.
  function automatic in_t legalize(input in_t c);
    int unsigned w;
    int unsigned h;
    int unsigned cw;
    int unsigned ch;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (c.op == OP_CLEAR && w * h > CHEAP_AREA) c.op = OP_READ;
    if (c.op == OP_FILL && c.pos_x < w && c.pos_y < h) begin
      cw = (c.rect_width > w - c.pos_x) ? w - c.pos_x : c.rect_width;
      ch = (c.rect_height > h - c.pos_y) ? h - c.pos_y : c.rect_height;
      if (cw * ch > CHEAP_AREA) begin
        c.rect_width[15:6]  = '0;
        c.rect_height[15:6] = '0;
      end
    end
    if (c.op == OP_READ && c.pos_x < w && c.pos_y < h) begin
      if (!surf_set[c.pos_y * w + c.pos_x]) c.pos_x[15] = 1'b1;
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_len();
    int unsigned q;
    q = $urandom_range(0, 99);
    if (q < 8) return 16'd0;
    if (q < 70) return 16'($urandom_range(1, 8));
    if (q < 85) return 16'($urandom_range(9, 40));
    if (q < 93) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom);
  endfunction

  function automatic logic [9:0] pick_dim();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return 10'($urandom_range(8, 64));
    if (p < 85) return 10'($urandom_range(0, 7));
    return 10'($urandom_range(65, 1023));
  endfunction

  task automatic send_cmd(input in_t c);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    draw_results_q.push_back(predict_draw(c));
    cmd_count++;
    op_count[c.op]++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (draw_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic set_surface(input logic [9:0] w_raw, input logic [9:0] h_raw);
    wait_drained();
    apb_write(ADDR_WIDTH, 32'(w_raw));
    apb_write(ADDR_HEIGHT, 32'(h_raw));
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    width_reg  = w_raw;
    height_reg = h_raw;
  endtask

  task automatic run_draw_mix(input int unsigned n);
    int unsigned w;
    int unsigned h;
    int unsigned done_n;
    int unsigned p;
    int unsigned run_len;
    int unsigned x0;
    int unsigned y0;
    in_t         c;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    done_n = 0;
    while (done_n < n) begin
      p = $urandom_range(0, 99);
      c = draw_cmd(OP_READ, 0, 0, $urandom, $urandom, $urandom, 8'($urandom));
      if (p < 40) begin
        x0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, w + 4);
        y0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, h + 4);
        run_len = $urandom_range(1, 6);
        c.op    = OP_GLYPH;
        c.pos_x = 16'(x0);
        c.pos_y = 16'(y0);
        for (int unsigned k = 0; k < run_len && done_n < n; k++) begin
          c.char_code = pick_char();
          send_cmd(c);
          c.pos_x = c.pos_x + 16'd8;
          done_n++;
        end
        last_x = x0;
        last_y = y0;
      end else begin
        if (p < 65) begin
          c.op          = OP_FILL;
          c.pos_x       = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, w + 2));
          c.pos_y       = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, h + 2));
          c.rect_width  = pick_len();
          c.rect_height = pick_len();
          last_x        = c.pos_x;
          last_y        = c.pos_y;
        end else if (p < 88) begin
          c.op = OP_READ;
          if ($urandom_range(0, 3) == 0) begin
            c.pos_x = 16'($urandom_range(0, w - 1));
            c.pos_y = 16'($urandom_range(0, h - 1));
          end else begin
            c.pos_x = 16'(last_x + $urandom_range(0, 9));
            c.pos_y = 16'(last_y + $urandom_range(0, 17));
          end
        end else if (p < 92) begin
          c.op = OP_CLEAR;
        end else begin
          c.op          = op_e'($urandom_range(0, 3));
          c.pos_x       = 16'($urandom);
          c.pos_y       = 16'($urandom);
          c.rect_width  = 16'($urandom);
          c.rect_height = 16'($urandom);
        end
        send_cmd(legalize(c));
        done_n++;
      end
    end
  endtask

  task automatic test_default_surface();
    send_cmd(draw_cmd(OP_CLEAR, 3, 3, 1, 1, 32'h1234_5678, 8'h41));
    send_cmd(draw_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(draw_cmd(OP_READ, 7, 7, 0, 0, 0, 0));
    send_cmd(draw_cmd(OP_READ, 8, 0, 0, 0, 0, 0));
    send_cmd(draw_cmd(OP_READ, 0, 8, 0, 0, 0, 0));
    send_cmd(draw_cmd(OP_FILL, 0, 0, 0, 5, 32'hFFFF_FFFF, 8'h00));
    send_cmd(draw_cmd(OP_FILL, 0, 0, 5, 0, 32'hFFFF_FFFF, 8'h00));
    send_cmd(draw_cmd(OP_FILL, 8, 0, 1, 1, 32'hFFFF_FFFF, 8'h00));
    send_cmd(draw_cmd(OP_FILL, 0, 8, 1, 1, 32'hFFFF_FFFF, 8'h00));
    send_cmd(draw_cmd(OP_FILL, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF, 8'hFF));
    send_cmd(draw_cmd(OP_FILL, 0, 0, 65535, 65535, 32'h0000_0000, 8'h00));
    send_cmd(draw_cmd(OP_FILL, 6, 5, 4, 4, 32'hA5C3_0F96, 8'h00));
    send_cmd(draw_cmd(OP_READ, 7, 7, 0, 0, 0, 0));
  endtask

  task automatic test_glyph_edges();
    send_cmd(draw_cmd(OP_GLYPH, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'h20));
    send_cmd(draw_cmd(OP_GLYPH, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'h7F));
    send_cmd(draw_cmd(OP_GLYPH, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'hFF));
    send_cmd(draw_cmd(OP_GLYPH, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'h00));
    send_cmd(draw_cmd(OP_GLYPH, 0, 0, 0, 0, 32'h00FF_00FF, 8'h21));
    send_cmd(draw_cmd(OP_GLYPH, 3, 1, 0, 0, 32'h8000_0001, 8'h7E));
    send_cmd(draw_cmd(OP_GLYPH, 65535, 65535, 0, 0, 32'h1111_1111, 8'h41));
    send_cmd(draw_cmd(OP_GLYPH, 0, 2, 0, 0, 32'h2222_2222, 8'h48));
    send_cmd(draw_cmd(OP_GLYPH, 8, 2, 0, 0, 32'h2222_2222, 8'h69));
    send_cmd(draw_cmd(OP_READ, 0, 4, 0, 0, 0, 0));
    send_cmd(draw_cmd(OP_READ, 1, 5, 0, 0, 0, 0));
  endtask

  task automatic test_size_extremes();
    logic [9:0]  w_set [3];
    logic [9:0]  h_set [3];
    int unsigned w;
    int unsigned h;
    w_set = '{10'd1023, 10'd7, 10'd512};
    h_set = '{10'd0, 10'd513, 10'd512};
    for (int i = 0; i < 3; i++) begin
      set_surface(w_set[i], h_set[i]);
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      send_cmd(draw_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
      send_cmd(draw_cmd(OP_FILL, w - 1, h - 1, 65535, 65535, 32'hC0DE_F00D, 8'h00));
      send_cmd(draw_cmd(OP_GLYPH, w - 5, h - 9, 0, 0, 32'h0BAD_CAFE, 8'h5A));
      send_cmd(draw_cmd(OP_READ, w - 1, h - 1, 0, 0, 0, 0));
      send_cmd(draw_cmd(OP_READ, w, 0, 0, 0, 0, 0));
      send_cmd(draw_cmd(OP_READ, 0, h, 0, 0, 0, 0));
    end
  endtask

  task automatic test_random_draws(input int unsigned phases, input int unsigned per_phase);
    for (int unsigned ph = 0; ph < phases; ph++) begin
      set_surface(pick_dim(), pick_dim());
      idle_on = (ph % 3 != 2);
      send_cmd(legalize(draw_cmd(OP_CLEAR, 0, 0, 0, 0, $urandom, 8'($urandom))));
      run_draw_mix(per_phase);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    set_surface(10'd24, 10'd40);
    idle_on = 1'b0;
    run_draw_mix(80);
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    set_surface(10'd16, 10'd16);
    idle_on = 1'b0;
    hold_go = 1'b1;
    run_draw_mix(30);
    idle_on = 1'b1;
  endtask

  initial begin : result_check
    int unsigned stall_left;
    out_t        want;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (draw_results_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected beat, read_color=%h pixels_written=%0d", $time,
                   out_data_o.read_color, out_data_o.pixels_written);
        end else begin
          want = draw_results_q.pop_front();
          if (out_data_o.read_color !== want.read_color) begin
            err_count++;
            $display("%0t: read_color mismatch, expected %h, got %h", $time,
                     want.read_color, out_data_o.read_color);
          end
          if (out_data_o.pixels_written !== want.pixels_written) begin
            err_count++;
            $display("%0t: pixels_written mismatch, expected %0d, got %0d", $time,
                     want.pixels_written, out_data_o.pixels_written);
          end
        end
      end
      if (hold_go) begin
        hold_go    = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #400_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    idle_on      = 1'b1;
    hold_go      = 1'b0;
    err_count    = 0;
    cmd_count    = 0;
    result_count = 0;
    last_x       = 0;
    last_y       = 0;
    width_reg    = RESET_DIM;
    height_reg   = RESET_DIM;
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_surface();
    test_glyph_edges();
    test_size_extremes();
    test_random_draws(6, 300);
    test_back_to_back();
    test_output_stall();
    wait_drained();
    repeat (32) @(posedge clk_i);
    $display("Sent %0d commands (fill %0d, clear %0d, glyph %0d, read %0d), checked %0d results,",
             cmd_count, op_count[OP_FILL], op_count[OP_CLEAR], op_count[OP_GLYPH],
             op_count[OP_READ], result_count);
    $display("over default, extreme and random surface sizes with a long output stall.");
    if (err_count == 0 && draw_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
